[rtl/midi_note_to_cv_gate_assert.svh]
// Assertion macros for the MIDI note to CV/gate converter.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef MIDI_NOTE_TO_CV_GATE_ASSERT_SVH
`define MIDI_NOTE_TO_CV_GATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequence must hold in the same cycle as the antecedent.
`define MNC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MNC_ASSERT_NOW(label, ante, cons, msg)
`define MNC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/mnc_pkg.sv]
// Shared types and constants for the MIDI note to CV/gate converter.
// No dependencies; used by the parser, the voice and the top level.
package mnc_pkg;

	// One-hot byte parser states.
	typedef enum logic [2:0] {
		PS_IDLE = 3'b001,
		PS_NOTE = 3'b010,
		PS_VEL  = 3'b100
	} parse_state_t;

	typedef enum logic [1:0] {
		EVT_NOTE_ON      = 2'd0,
		EVT_NOTE_OFF     = 2'd1,
		EVT_OFF_IGNORED  = 2'd2
	} event_kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_IDX_CHANNEL = 2'd0;
	localparam logic [1:0] CFG_IDX_BASE    = 2'd1;
	localparam logic [1:0] CFG_IDX_STEP    = 2'd2;

	localparam logic [3:0]  RST_CHANNEL = 4'd0;
	localparam logic [6:0]  RST_BASE    = 7'd36;
	localparam logic [7:0]  RST_STEP    = 8'd51;

	// Upper nibble of the accepted status bytes.
	localparam logic [3:0]  STATUS_NOTE_ON  = 4'h9;
	localparam logic [3:0]  STATUS_NOTE_OFF = 4'h8;

	localparam logic [11:0] CV_MAX = 12'hFFF;

	// A completed note message from the parser.
	typedef struct packed {
		logic       is_off;
		logic [6:0] note;
		logic [6:0] velocity;
	} msg_t;

	// One result word.
	typedef struct packed {
		event_kind_t kind;
		logic        gate;
		logic [11:0] cv;
		logic [6:0]  note;
		logic [6:0]  velocity;
	} result_t;

endpackage

[rtl/midi_note_to_cv_gate.sv]
// Monophonic MIDI note to CV/gate converter, top level.
// Depends on mnc_pkg, mnc_parser, mnc_voice and midi_note_to_cv_gate_assert.svh.
//
// Raw MIDI bytes enter one word at a time on the s_ stream channel (rx_byte in
// s_tdata[7:0]). Note on and note off messages for the configured channel are
// parsed with running status; every completed message yields one result word on
// the m_ stream channel, all other bytes yield none. A message passes from the
// input register to the output register. One byte per cycle is taken while no
// result stalls; in between lie the parser step, a 7x8 multiply and saturation.
// Reset clears the parser, the voice state (gate low, CV zero, no last note) and
// loads the configuration defaults: channel 0, base note 36, 51 codes a semitone.
// If the receiver stalls, the result word waits in the output register and the
// byte behind it waits in the input register; s_tready drops only when that
// byte would complete another message. Bytes that complete nothing still pass.
// Configuration is written on the cfg_ channel, which is always ready, and must
// only be written while no byte is in flight.
`include "midi_note_to_cv_gate_assert.svh"

module midi_note_to_cv_gate (
	input  logic        clk,
	input  logic        arst_n,
	// Byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] gate, [12:1] cv_value, [19:13] note_number,
	                               // [26:20] velocity, [31:27] zero
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mnc_pkg::*;

	// Configuration registers.
	logic [3:0] channel_q;
	logic [6:0] base_note_q;
	logic [7:0] step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q   <= RST_CHANNEL;
			base_note_q <= RST_BASE;
			step_q      <= RST_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_CHANNEL: channel_q   <= cfg_data[3:0];
				CFG_IDX_BASE:    base_note_q <= cfg_data[6:0];
				CFG_IDX_STEP:    step_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: one received byte waiting to be parsed.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Output register holding the result word.
	logic    out_valid_q;
	result_t result_q;

	logic    msg_valid, out_free, advance, commit;
	msg_t    msg;
	result_t result;

	// The byte in the input register moves on when it completes nothing, or
	// when the output register is empty or being emptied in this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!msg_valid || out_free);
	assign commit   = advance && msg_valid;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	mnc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.rx_byte   (byte_s1),
		.channel   (channel_q),
		.msg_valid (msg_valid),
		.msg       (msg)
	);

	mnc_voice u_voice (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.msg       (msg),
		.base_note (base_note_q),
		.step      (step_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, result_q.velocity, result_q.note, result_q.cv, result_q.gate};
	assign m_tuser  = result_q.kind;

	// A fresh result word must come from a byte that was waiting in the input register.
	`MNC_ASSERT_NOW(a_result_from_s1, $rose(m_tvalid), $past(valid_s1), "result without a byte")
	// A note on always leaves the gate high.
	`MNC_ASSERT_NOW(a_note_on_gate, m_tvalid && (m_tuser == EVT_NOTE_ON), m_tdata[0],
		"note on with gate low")
	// An applied note off always leaves the gate low.
	`MNC_ASSERT_NOW(a_note_off_gate, m_tvalid && (m_tuser == EVT_NOTE_OFF), !m_tdata[0],
		"note off with gate high")
	// The byte side is only held off while a byte waits on a stalled result.
	`MNC_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && msg_valid && out_valid_q && !m_tready,
		"input stalled without cause")

endmodule

[rtl/mnc_parser.sv]
// MIDI byte parser for note on and note off messages with running status.
// Depends on mnc_pkg.
module mnc_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    rx_byte,
	input  logic [3:0]    channel,
	output logic          msg_valid,
	output mnc_pkg::msg_t msg
);
	import mnc_pkg::*;

	parse_state_t state_q, state_d;
	logic         off_q, off_d;
	logic [6:0]   pend_q, pend_d;

	logic is_status, match_on, match_off, match_any;

	assign is_status = rx_byte[7];
	assign match_on  = (rx_byte[7:4] == STATUS_NOTE_ON) && (rx_byte[3:0] == channel);
	assign match_off = (rx_byte[7:4] == STATUS_NOTE_OFF) && (rx_byte[3:0] == channel);
	assign match_any = match_on || match_off;

	always_comb begin
		state_d   = state_q;
		off_d     = off_q;
		pend_d    = pend_q;
		msg_valid = 1'b0;
		unique case (state_q)
			PS_IDLE: begin
				state_d = match_any ? PS_NOTE : PS_IDLE;
				if (match_any) begin
					off_d = match_off;
				end
			end
			PS_NOTE: begin
				if (is_status) begin
					state_d = match_any ? PS_NOTE : PS_IDLE;
					if (match_any) begin
						off_d = match_off;
					end
				end else begin
					pend_d  = rx_byte[6:0];
					state_d = PS_VEL;
				end
			end
			PS_VEL: begin
				if (is_status) begin
					state_d = match_any ? PS_NOTE : PS_IDLE;
					if (match_any) begin
						off_d = match_off;
					end
				end else begin
					// Message complete; running status waits for the next note.
					msg_valid = 1'b1;
					state_d   = PS_NOTE;
				end
			end
			default: begin
				state_d = PS_IDLE;
			end
		endcase
	end

	assign msg.is_off   = off_q;
	assign msg.note     = pend_q;
	assign msg.velocity = rx_byte[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			off_q   <= 1'b0;
			pend_q  <= 7'd0;
		end else if (advance) begin
			state_q <= state_d;
			off_q   <= off_d;
			pend_q  <= pend_d;
		end
	end

endmodule

[rtl/mnc_voice.sv]
// Monophonic voice: last-note tracking, gate level and saturated pitch CV.
// Depends on mnc_pkg.
module mnc_voice (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  mnc_pkg::msg_t    msg,
	input  logic [6:0]       base_note,
	input  logic [7:0]       step,
	output mnc_pkg::result_t result
);
	import mnc_pkg::*;

	logic [6:0]  last_note_q;
	logic        last_valid_q;
	logic        gate_q;
	logic [11:0] cv_q;

	logic        off_evt, below, match;
	logic [6:0]  diff;
	logic [14:0] prod;
	logic [11:0] cv_new;

	assign off_evt = msg.is_off || (msg.velocity == 7'd0);
	assign below   = (msg.note <= base_note);
	assign diff    = msg.note - base_note;
	assign prod    = 15'(diff) * 15'(step);
	assign cv_new  = below ? 12'd0 : ((prod > 15'(CV_MAX)) ? CV_MAX : prod[11:0]);
	assign match   = last_valid_q && (msg.note == last_note_q);

	always_comb begin
		result.note     = msg.note;
		result.velocity = msg.velocity;
		result.cv       = cv_q;
		if (!off_evt) begin
			result.kind = EVT_NOTE_ON;
			result.gate = 1'b1;
			result.cv   = cv_new;
		end else if (match) begin
			result.kind = EVT_NOTE_OFF;
			result.gate = 1'b0;
		end else begin
			result.kind = EVT_OFF_IGNORED;
			result.gate = gate_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_note_q  <= 7'd0;
			last_valid_q <= 1'b0;
			gate_q       <= 1'b0;
			cv_q         <= 12'd0;
		end else if (commit) begin
			gate_q <= result.gate;
			cv_q   <= result.cv;
			if (!off_evt) begin
				last_note_q  <= msg.note;
				last_valid_q <= 1'b1;
			end
		end
	end

endmodule
